@@ rtl/core/pixel_format_packer_assert.svh @@
// ---------------------------------------------------------------------------
// Pixel format packer assertion macros
// Concurrent property shorthands shared by the packer RTL.
// ---------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_PACKER_ASSERT_SVH
`define PIXEL_FORMAT_PACKER_ASSERT_SVH

// Same-cycle implication.
`define PFP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pfp_pkg.sv @@
// ---------------------------------------------------------------------------
// Pixel format packer package
// Mode codes, widths and the mono threshold.
// ---------------------------------------------------------------------------
package pfp_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned MAX_BYTES   = 4;
  localparam int unsigned REM_W       = 3;
  localparam int unsigned BITCNT_W    = 3;

  localparam logic [SUM_W-1:0] MONO_THRESHOLD = SUM_W'(384);

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_MONO       = 2'd0;
  localparam mode_t MODE_RGB        = 2'd1;
  localparam mode_t MODE_ARGB       = 2'd2;
  localparam mode_t MODE_ARGB_ALIAS = 2'd3;

endpackage

@@ rtl/core/pixel_format_packer.sv @@
// ---------------------------------------------------------------------------
// Pixel format packer
// Turns a pixel stream into 1-bit threshold, RGB24 or ARGB32 bytes.
// ---------------------------------------------------------------------------
//  channel | signals                                   | role
//  pixel   | pixel_valid, pixel_stall, red..frame_end  | one pixel per transfer
//  byte    | byte_valid, byte_stall, out_byte, run_last| one byte per transfer
//  config  | cfg_we, cfg_wdata                         | pixel_mode write
//
//  A pixel enters the staging register, which holds up to four bytes; bytes
//  leave one per cycle through the output register while byte_stall is low;
//  ARGB32 stages 4 bytes per pixel, RGB24 3, mono 1 per 8 pixels or frame_end.
//  A new pixel is taken in the cycle the last staged byte moves out.
//  rst is synchronous and clears mode, mono state and all valid state.
//  byte_stall holds the output register and, with one staged byte left, the
//  input; with more than one staged byte left the input is held regardless.
`include "pixel_format_packer_assert.svh"

module pixel_format_packer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] alpha,
  input  logic       frame_end,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] out_byte,
  output logic       run_last
);

  pfp_pkg::mode_t                    pixel_mode;
  logic [7:0]                        mono_shift;
  logic [pfp_pkg::BITCNT_W-1:0]      mono_bit_count;
  logic [7:0]                        stage_byte [pfp_pkg::MAX_BYTES];
  logic [pfp_pkg::REM_W-1:0]         stage_rem;

  logic [7:0]                        stage_byte_next [pfp_pkg::MAX_BYTES];
  logic [pfp_pkg::REM_W-1:0]         stage_rem_next;
  logic [7:0]                        mono_shift_next;
  logic [pfp_pkg::BITCNT_W-1:0]      mono_bit_count_next;

  logic [pfp_pkg::SUM_W-1:0]         pix_sum;
  logic                              mono_bit;
  logic [7:0]                        mono_word;
  logic [pfp_pkg::BITCNT_W:0]        count_inc;
  logic [pfp_pkg::BITCNT_W:0]        pad_amt;
  logic                              move;
  logic                              pix_acc;

  assign move        = (stage_rem != '0) && (!byte_valid || !byte_stall);
  assign pixel_stall = !((stage_rem == '0) || ((stage_rem == 3'd1) && move));
  assign pix_acc     = pixel_valid && !pixel_stall;

  assign pix_sum   = pfp_pkg::SUM_W'(red) + pfp_pkg::SUM_W'(green)
                   + pfp_pkg::SUM_W'(blue);
  assign mono_bit  = (pix_sum >= pfp_pkg::MONO_THRESHOLD);
  assign mono_word = {mono_shift[6:0], mono_bit};
  assign count_inc = {1'b0, mono_bit_count} + 4'd1;
  assign pad_amt   = 4'd8 - count_inc;

  always_comb begin
    stage_byte_next     = stage_byte;
    stage_rem_next      = '0;
    mono_shift_next     = mono_shift;
    mono_bit_count_next = mono_bit_count;
    unique case (pixel_mode) inside
      pfp_pkg::MODE_MONO: begin
        stage_byte_next[0] = mono_word;
        if (count_inc == 4'd8) begin
          stage_rem_next      = 3'd1;
          mono_shift_next     = '0;
          mono_bit_count_next = '0;
        end else if (frame_end) begin
          stage_byte_next[0]  = mono_word << pad_amt;
          stage_rem_next      = 3'd1;
          mono_shift_next     = '0;
          mono_bit_count_next = '0;
        end else begin
          mono_shift_next     = mono_word;
          mono_bit_count_next = count_inc[pfp_pkg::BITCNT_W-1:0];
        end
      end
      pfp_pkg::MODE_RGB: begin
        stage_byte_next[0] = red;
        stage_byte_next[1] = green;
        stage_byte_next[2] = blue;
        stage_rem_next     = 3'd3;
      end
      pfp_pkg::MODE_ARGB, pfp_pkg::MODE_ARGB_ALIAS: begin
        stage_byte_next[0] = alpha;
        stage_byte_next[1] = red;
        stage_byte_next[2] = green;
        stage_byte_next[3] = blue;
        stage_rem_next     = 3'd4;
      end
      default: begin
        stage_rem_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode     <= pfp_pkg::MODE_MONO;
      mono_shift     <= '0;
      mono_bit_count <= '0;
      stage_rem      <= '0;
      byte_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        pixel_mode <= cfg_wdata;
      end
      if (pix_acc) begin
        mono_shift     <= mono_shift_next;
        mono_bit_count <= mono_bit_count_next;
        stage_rem      <= stage_rem_next;
      end else if (move) begin
        stage_rem <= stage_rem - 3'd1;
      end
      if (move) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      stage_byte <= stage_byte_next;
    end else if (move) begin
      for (int i = 0; i < pfp_pkg::MAX_BYTES - 1; i++) begin
        stage_byte[i] <= stage_byte[i+1];
      end
    end
    if (move) begin
      out_byte <= stage_byte[0];
      run_last <= (stage_rem == 3'd1);
    end
  end

  `PFP_ASSERT_SAME(a_accept_when_drained, clk, rst, pix_acc,
    (stage_rem == 3'd0) || ((stage_rem == 3'd1) && move),
    "pixel transfer while staged bytes remain")
  `PFP_ASSERT_SAME(a_rem_bound, clk, rst, 1'b1, stage_rem <= 3'd4,
    "staged byte count above four")
  `PFP_ASSERT_NEXT(a_last_marks_run, clk, rst, move,
    run_last == $past(stage_rem == 3'd1), "run_last does not match staged count")
  `PFP_ASSERT_NEXT(a_frame_end_flush, clk, rst,
    pix_acc && (pixel_mode == pfp_pkg::MODE_MONO) && frame_end,
    (mono_bit_count == '0) && (stage_rem == 3'd1), "mono flush did not clear count")

endmodule
